FILE: hdl/mlfq_pkg.sv
// Shared types, constants and helpers for the feedback queue scheduler.
`default_nettype none
package mlfq_pkg;

    localparam int NUM_TASKS   = 16;
    localparam int LEVELS      = 4;
    localparam int TASK_W      = 4;
    localparam int LVL_W       = 2;
    localparam int REMAIN_BITS = 16;
    localparam int QUANT_W     = 20;
    localparam int TIME_W      = 32;
    localparam int IDX_BITS    = $clog2(NUM_TASKS);
    localparam int CNT_BITS    = $clog2(NUM_TASKS + 1);

    typedef logic [TASK_W-1:0]      task_t;
    typedef logic [LVL_W-1:0]       lvl_t;
    typedef logic [IDX_BITS-1:0]    idx_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [REMAIN_BITS-1:0] rem_t;
    typedef logic [QUANT_W-1:0]     quant_t;
    typedef logic [TIME_W-1:0]      time_t;
    typedef logic [LEVELS-1:0][CNT_BITS-1:0] cnt_vec_t;
    typedef logic [LEVELS-1:0][TASK_W-1:0]   task_vec_t;

    localparam cnt_t CNT_FULL = cnt_t'(NUM_TASKS);
    localparam idx_t IDX_LAST = idx_t'(NUM_TASKS - 1);
    localparam lvl_t LVL_MAX  = lvl_t'(LEVELS - 1);

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef enum logic [1:0] {
        ST_ARR_OK  = 2'd0,
        ST_ARR_REJ = 2'd1,
        ST_IDLE    = 2'd2,
        ST_RUN     = 2'd3
    } status_t;

    typedef struct packed {
        logic  req_type;
        task_t task_id;
        rem_t  burst;
    } sched_in_t;

    typedef struct packed {
        status_t status;
        task_t   task_res;
        lvl_t    level;
        rem_t    remaining_after;
        logic    finished;
        logic    preempted;
        time_t   time_now;
    } sched_out_t;

    typedef struct packed {
        logic  push_en;
        logic  at_head;
        lvl_t  push_lvl;
        task_t push_task;
        logic  pop_en;
        lvl_t  pop_lvl;
    } q_ctrl_t;

    function automatic idx_t idx_inc(idx_t i);
        return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t idx_dec(idx_t i);
        return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
    endfunction

    function automatic idx_t idx_add(idx_t h, cnt_t c);
        logic [CNT_BITS:0] s;
        s = (CNT_BITS + 1)'(h) + (CNT_BITS + 1)'(c);
        if (s >= (CNT_BITS + 1)'(NUM_TASKS))
            s = s - (CNT_BITS + 1)'(NUM_TASKS);
        return idx_t'(s);
    endfunction

    // found flag on top, then the lowest-numbered (highest-priority) nonempty level
    function automatic logic [LVL_W:0] top_level(cnt_vec_t c);
        logic [LVL_W:0] r;
        r = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (c[i] != '0)
                r = {1'b1, lvl_t'(i)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/mlfq_queue_bank.sv
// Per-level ring queues of task numbers with head and tail push and head pop.
`default_nettype none
module mlfq_queue_bank (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mlfq_pkg::q_ctrl_t   ctrl,
    output mlfq_pkg::cnt_vec_t       counts,
    output mlfq_pkg::task_vec_t      head_task
);
    import mlfq_pkg::*;

    task_t slots [LEVELS][NUM_TASKS];
    idx_t  heads_reg  [LEVELS];
    idx_t  heads_next [LEVELS];
    cnt_vec_t counts_reg, counts_next;
    logic  wr_en  [LEVELS];
    idx_t  wr_idx [LEVELS];

    always_comb
    begin
        idx_t h;
        cnt_t c;
        for (int l = 0; l < LEVELS; l++)
        begin
            h = heads_reg[l];
            c = counts_reg[l];
            wr_en[l]  = 1'b0;
            wr_idx[l] = h;
            if (ctrl.push_en && ctrl.push_lvl == lvl_t'(l) && c < CNT_FULL)
            begin
                wr_en[l] = 1'b1;
                if (ctrl.at_head)
                begin
                    h = idx_dec(h);
                    wr_idx[l] = h;
                end
                else
                begin
                    wr_idx[l] = idx_add(h, c);
                end
                c = cnt_t'(c + 1'b1);
            end
            if (ctrl.pop_en && ctrl.pop_lvl == lvl_t'(l) && c != '0)
            begin
                h = idx_inc(h);
                c = cnt_t'(c - 1'b1);
            end
            heads_next[l]  = h;
            counts_next[l] = c;
            head_task[l]   = slots[l][heads_reg[l]];
        end
    end

    assign counts = counts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
            for (int l = 0; l < LEVELS; l++)
                heads_reg[l] <= '0;
        end
        else
        begin
            counts_reg <= counts_next;
            for (int l = 0; l < LEVELS; l++)
                heads_reg[l] <= heads_next[l];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            if (wr_en[l])
                slots[l][wr_idx[l]] <= ctrl.push_task;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/mlfq_tick_scheduler_core.sv
// Top level: four-level feedback queue scheduler, one item per cycle.
//
// Items enter on start with item; busy stays low, so an item is taken in
// every cycle that start is high. Each item yields exactly one result beat
// on result, marked by result_valid for one cycle, once the item has passed
// the input register and then the result register. The sustained
// rate is one item per cycle: the settle, pick and run of a tick are one
// pass through the queue counts, one ring queue push and pop and one
// read-modify-write of the remaining-time table.
// Quantum registers are written on the cfg channel (cfg_ready is always
// high); index i sets the slice of level i, and a zero acts as one.
// Reset clears the queues, the active flags, the running task and the tick
// count, and restores the quanta to 2, 4, 8 and 1000000. The receiver
// cannot stall: every result beat must be taken in its cycle.
`default_nettype none
module mlfq_tick_scheduler_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire mlfq_pkg::sched_in_t           item,
    output logic                               result_valid,
    output mlfq_pkg::sched_out_t               result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mlfq_pkg::LVL_W-1:0]    cfg_index,
    input  wire logic [mlfq_pkg::QUANT_W-1:0]  cfg_data
);
    import mlfq_pkg::*;

    logic       stage_valid_reg;
    sched_in_t  stage_item_reg;
    quant_t     quantum_reg [LEVELS];
    rem_t       rem_table [NUM_TASKS];
    logic [NUM_TASKS-1:0] active_reg, active_next;
    logic       cur_valid_reg, cur_valid_next;
    task_t      cur_task_reg, cur_task_next;
    lvl_t       cur_level_reg, cur_level_next;
    quant_t     slice_reg, slice_next;
    rem_t       cur_rem_reg, cur_rem_next;
    time_t      tick_reg, tick_next;
    sched_out_t result_reg, result_next;
    logic       result_valid_reg;

    q_ctrl_t    qctrl;
    cnt_vec_t   counts;
    task_vec_t  head_task;

    logic       rem_we;
    task_t      rem_widx;
    rem_t       rem_wdata;

    mlfq_queue_bank u_queues (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (qctrl),
        .counts    (counts),
        .head_task (head_task)
    );

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic           ok;
        logic [LVL_W:0] top0;
        logic [LVL_W:0] top1;
        logic           preempt;
        logic           slice_out;
        logic           push_ok;
        lvl_t           pl;
        cnt_vec_t       cnt1;
        logic           run;
        task_t          tsk;
        lvl_t           lvl;
        rem_t           rem;
        rem_t           rem_after;
        quant_t         slice;
        quant_t         q;

        active_next    = active_reg;
        cur_valid_next = cur_valid_reg;
        cur_task_next  = cur_task_reg;
        cur_level_next = cur_level_reg;
        slice_next     = slice_reg;
        cur_rem_next   = cur_rem_reg;
        tick_next      = tick_reg;
        result_next    = '0;
        qctrl          = '0;
        rem_we         = 1'b0;
        rem_widx       = stage_item_reg.task_id;
        rem_wdata      = stage_item_reg.burst;
        ok = 1'b0; top0 = '0; top1 = '0; preempt = 1'b0; slice_out = 1'b0;
        push_ok = 1'b0; pl = '0; cnt1 = counts; run = 1'b0;
        tsk = '0; lvl = '0; rem = '0; rem_after = '0; slice = '0; q = '0;

        if (stage_valid_reg)
        begin
            if (stage_item_reg.req_type == REQ_ARRIVAL)
            begin
                ok = stage_item_reg.burst != '0
                     && !active_reg[stage_item_reg.task_id]
                     && counts[0] < CNT_FULL;
                if (ok)
                begin
                    qctrl.push_en   = 1'b1;
                    qctrl.push_lvl  = '0;
                    qctrl.push_task = stage_item_reg.task_id;
                    active_next[stage_item_reg.task_id] = 1'b1;
                    rem_we = 1'b1;
                end
                result_next.status          = ok ? ST_ARR_OK : ST_ARR_REJ;
                result_next.task_res        = stage_item_reg.task_id;
                result_next.remaining_after = ok ? stage_item_reg.burst : '0;
                result_next.time_now        = tick_reg;
            end
            else
            begin
                // settle the task that ran last tick
                top0 = top_level(counts);
                preempt = cur_valid_reg && top0[LVL_W]
                          && lvl_t'(top0[LVL_W-1:0]) < cur_level_reg;
                slice_out = cur_valid_reg && !preempt && slice_reg == '0;
                pl = preempt ? cur_level_reg
                     : ((cur_level_reg == LVL_MAX) ? cur_level_reg
                        : lvl_t'(cur_level_reg + 1'b1));
                push_ok = (preempt || slice_out) && counts[pl] < CNT_FULL;
                if (push_ok)
                    cnt1[pl] = cnt_t'(counts[pl] + 1'b1);
                qctrl.push_en    = push_ok;
                qctrl.at_head    = preempt;
                qctrl.push_lvl   = pl;
                qctrl.push_task  = cur_task_reg;
                tick_next        = time_t'(tick_reg + 1'b1);
                run = 1'b1;

                if (cur_valid_reg && !preempt && !slice_out)
                begin
                    tsk   = cur_task_reg;
                    lvl   = cur_level_reg;
                    rem   = cur_rem_reg;
                    slice = slice_reg;
                end
                else
                begin
                    top1 = top_level(cnt1);
                    if (!top1[LVL_W])
                    begin
                        run = 1'b0;
                        cur_valid_next        = 1'b0;
                        result_next.status    = ST_IDLE;
                        result_next.preempted = preempt;
                        result_next.time_now  = tick_next;
                    end
                    else
                    begin
                        lvl = lvl_t'(top1[LVL_W-1:0]);
                        qctrl.pop_en  = 1'b1;
                        qctrl.pop_lvl = lvl;
                        tsk = (push_ok && pl == lvl && (preempt || counts[pl] == '0))
                              ? cur_task_reg : head_task[lvl];
                        rem = rem_table[tsk];
                        q   = (quantum_reg[lvl] == '0) ? quant_t'(1) : quantum_reg[lvl];
                        slice = (quant_t'(rem) < q) ? quant_t'(rem) : q;
                    end
                end

                if (run)
                begin
                    rem_after = (rem != '0) ? rem_t'(rem - 1'b1) : rem;
                    rem_we    = 1'b1;
                    rem_widx  = tsk;
                    rem_wdata = rem_after;
                    cur_valid_next = rem_after != '0;
                    cur_task_next  = tsk;
                    cur_level_next = lvl;
                    cur_rem_next   = rem_after;
                    slice_next = (slice != '0) ? quant_t'(slice - 1'b1) : slice;
                    if (rem_after == '0)
                        active_next[tsk] = 1'b0;
                    result_next.status          = ST_RUN;
                    result_next.task_res        = tsk;
                    result_next.level           = lvl;
                    result_next.remaining_after = rem_after;
                    result_next.finished        = rem_after == '0;
                    result_next.preempted       = preempt;
                    result_next.time_now        = tick_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            active_reg       <= '0;
            cur_valid_reg    <= 1'b0;
            cur_task_reg     <= '0;
            cur_level_reg    <= '0;
            slice_reg        <= '0;
            cur_rem_reg      <= '0;
            tick_reg         <= '0;
            quantum_reg[0]   <= quant_t'(2);
            quantum_reg[1]   <= quant_t'(4);
            quantum_reg[2]   <= quant_t'(8);
            quantum_reg[3]   <= quant_t'(1000000);
        end
        else
        begin
            stage_valid_reg  <= start && !busy;
            result_valid_reg <= stage_valid_reg;
            active_reg       <= active_next;
            cur_valid_reg    <= cur_valid_next;
            cur_task_reg     <= cur_task_next;
            cur_level_reg    <= cur_level_next;
            slice_reg        <= slice_next;
            cur_rem_reg      <= cur_rem_next;
            tick_reg         <= tick_next;
            if (cfg_valid && cfg_ready)
                quantum_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            stage_item_reg <= item;
        result_reg <= result_next;
        if (rem_we)
            rem_table[rem_widx] <= rem_wdata;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 result_valid)
        else $error("result beat missing two cycles after item");

    a_finish_runs: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.finished |-> result.status == ST_RUN)
        else $error("finished flag on a beat without a run");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_IDLE |-> result.task_res == '0
        && result.remaining_after == '0)
        else $error("idle tick carries task data");
`endif

endmodule
`default_nettype wire
